FILE: rtl/ccrn_pkg.sv
// Shared types and constants for the cross-channel response normalisation block.
// Used by ccrn_norm_unit and cross_channel_response_norm; depends on nothing.
package ccrn_pkg;

    localparam int CCRN_CFG_W   = 32;
    localparam int CCRN_ALPHA_W = 32;
    localparam int CCRN_BIAS_W  = 16;
    localparam int CCRN_CH_W    = 7;

    localparam logic [1:0] CCRN_CFG_ALPHA = 2'd0;
    localparam logic [1:0] CCRN_CFG_BIAS  = 2'd1;
    localparam logic [1:0] CCRN_CFG_COUNT = 2'd2;

    localparam logic [CCRN_ALPHA_W-1:0] CCRN_ALPHA_RST = 32'd85899;
    localparam logic [CCRN_BIAS_W-1:0]  CCRN_BIAS_RST  = 16'd256;
    localparam logic [CCRN_CH_W-1:0]    CCRN_COUNT_RST = 7'd96;

    localparam logic [CCRN_CH_W-1:0] CCRN_MIN_CHANNELS = 7'd5;
    localparam logic [CCRN_CH_W-1:0] CCRN_MAX_CHANNELS = 7'd96;

    localparam int CCRN_WIN = 5;

    // One normalisation job: centre slot and last window slot (newest is slot 0)
    typedef struct packed {
        logic [1:0] center;
        logic [2:0] last_idx;
    } t_job;

endpackage

FILE: rtl/ccrn_norm_unit.sv
// Iterative normalisation unit: one shared multiplier and one shared subtractor
// under a small sequencer. Depends on ccrn_pkg.
module ccrn_norm_unit
    import ccrn_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  t_job                                i_job,
    input  logic [CCRN_WIN-1:0][DATA_WIDTH-1:0] i_vals,
    input  logic [CCRN_ALPHA_W-1:0]             i_alpha,
    input  logic [CCRN_BIAS_W-1:0]              i_bias,
    input  logic                                i_ack,
    output logic                                o_done,
    output logic [DATA_WIDTH-1:0]               o_value
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = 2 * DW + 1;
    localparam int SHW  = SW - 16;
    localparam int TAW  = CCRN_ALPHA_W + SHW + 1;
    localparam int TW   = TAW - 16;
    localparam int DWD  = ((TW > 24) ? TW : 24) + 1;
    localparam int RW   = (DWD + 17) / 2;
    localparam int RH   = RW / 2;
    localparam int SQW  = DWD + RW;
    localparam int NSQ  = (SQW + 1) / 2;
    localparam int PW   = NSQ;
    localparam int NW   = DW + 16;
    localparam int CW   = $clog2(NW);
    localparam int UW   = SQW + 1;
    localparam int MA   = (DWD > CCRN_ALPHA_W) ? DWD : CCRN_ALPHA_W;
    localparam int MB0  = (DW > 16) ? DW : 16;
    localparam int MB1  = (MB0 > SHW) ? MB0 : SHW;
    localparam int MB   = (MB1 > (RW - RH)) ? MB1 : (RW - RH);

    localparam logic [SQW-1:0] BIT_INIT = SQW'(1) << (2 * (NSQ - 1));
    localparam logic [NW-1:0]  MAXP     = {{(NW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic [NW-1:0]  MAXP1    = MAXP + NW'(1);
    localparam logic [CW-1:0]  DIV_LAST = CW'(NW - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQ_ACC, S_AH, S_AH_ACC, S_AL, S_AL_ACC, S_D,
        S_SQRT1, S_RM_LO, S_RA_LO, S_RM_HI, S_RA_HI, S_SQRT2, S_DIV,
        S_SAT, S_DONE
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic [2:0]         r_k;
    logic [SW-1:0]      r_sum;
    logic [MA+MB-1:0]   r_prod;
    logic [TAW-1:0]     r_t;
    logic [DWD-1:0]     r_d;
    logic [SQW-1:0]     r_x;
    logic [SQW-1:0]     r_r;
    logic [SQW-1:0]     r_bit;
    logic [RW-1:0]      r_root;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_rem;
    logic [NW-1:0]      r_num;
    logic [NW-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic [DW-1:0]      r_mag;
    logic               r_neg;
    logic [DW-1:0]      r_value;

    logic [DW-1:0]      val_k;
    logic [DW-1:0]      mag_k;
    logic [MA-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic [SQW-1:0]     rb;
    logic [PW:0]        trial;
    logic [UW-1:0]      sub_a;
    logic [UW-1:0]      sub_b;
    logic [UW-1:0]      diff;
    logic               ge;
    logic [SQW-1:0]     r_next;
    logic [DWD-1:0]     d_next;
    logic [NW-1:0]      q_pos;
    logic [NW-1:0]      q_neg;

    assign val_k = i_vals[r_k];
    assign mag_k = val_k[DW-1] ? (~val_k + DW'(1)) : val_k;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = MA'(mag_k);
                mul_b = MB'(mag_k);
            end
            S_AH: begin
                mul_a = MA'(i_alpha);
                mul_b = MB'(r_sum[SW-1:16]);
            end
            S_AL: begin
                mul_a = MA'(i_alpha);
                mul_b = MB'(r_sum[15:0]);
            end
            S_RM_LO: begin
                mul_a = MA'(r_d);
                mul_b = MB'(r_root[RH-1:0]);
            end
            S_RM_HI: begin
                mul_a = MA'(r_d);
                mul_b = MB'(r_root[RW-1:RH]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rb    = r_r + r_bit;
    assign trial = {r_rem, r_num[NW-1]};

    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = UW'(trial);
            sub_b = UW'(r_p);
        end else begin
            sub_a = {1'b0, r_x};
            sub_b = {1'b0, rb};
        end
    end

    assign diff   = sub_a - sub_b;
    assign ge     = ~diff[UW-1];
    assign r_next = ge ? ((r_r >> 1) + r_bit) : (r_r >> 1);
    assign d_next = DWD'({i_bias, 8'b0}) + DWD'(r_t[TAW-1:16]);
    assign q_pos  = (r_q > MAXP) ? MAXP : r_q;
    assign q_neg  = (r_q > MAXP1) ? MAXP1 : r_q;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_job   <= i_job;
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_k == {1'b0, r_job.center}) begin
                        r_mag <= mag_k;
                        r_neg <= val_k[DW-1];
                    end
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sum <= r_sum + SW'(r_prod[2*DW-1:0]);
                    if (r_k == r_job.last_idx) begin
                        r_state <= S_AH;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_SQ;
                    end
                end
                S_AH: begin
                    r_state <= S_AH_ACC;
                end
                S_AH_ACC: begin
                    r_t     <= TAW'(r_prod[CCRN_ALPHA_W+SHW-1:0]);
                    r_state <= S_AL;
                end
                S_AL: begin
                    r_state <= S_AL_ACC;
                end
                S_AL_ACC: begin
                    r_t     <= r_t + TAW'(r_prod[CCRN_ALPHA_W+15:16]);
                    r_state <= S_D;
                end
                S_D: begin
                    r_d <= d_next;
                    if (d_next == '0) begin
                        r_q     <= (r_mag == '0) ? '0 : MAXP1;
                        r_state <= S_SAT;
                    end else begin
                        r_x     <= SQW'(d_next) << 16;
                        r_r     <= '0;
                        r_bit   <= BIT_INIT;
                        r_state <= S_SQRT1;
                    end
                end
                S_SQRT1: begin
                    if (ge) begin
                        r_x <= diff[SQW-1:0];
                    end
                    r_r   <= r_next;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_root  <= r_next[RW-1:0];
                        r_state <= S_RM_LO;
                    end
                end
                S_RM_LO: begin
                    r_state <= S_RA_LO;
                end
                S_RA_LO: begin
                    r_x     <= SQW'(r_prod[DWD+RH-1:0]);
                    r_state <= S_RM_HI;
                end
                S_RM_HI: begin
                    r_state <= S_RA_HI;
                end
                S_RA_HI: begin
                    r_x     <= r_x + (SQW'(r_prod[DWD+RW-RH-1:0]) << RH);
                    r_r     <= '0;
                    r_bit   <= BIT_INIT;
                    r_state <= S_SQRT2;
                end
                S_SQRT2: begin
                    if (ge) begin
                        r_x <= diff[SQW-1:0];
                    end
                    r_r   <= r_next;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_p   <= r_next[PW-1:0];
                        r_rem <= '0;
                        r_num <= {r_mag, 16'b0};
                        r_cnt <= '0;
                        if (r_next[PW-1:0] == '0) begin
                            r_q     <= MAXP1;
                            r_state <= S_SAT;
                        end else begin
                            r_q     <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? diff[PW-1:0] : trial[PW-1:0];
                    r_num <= r_num << 1;
                    r_q   <= {r_q[NW-2:0], ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_value <= r_neg ? (~q_neg[DW-1:0] + DW'(1)) : q_pos[DW-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_value = r_value;

endmodule

FILE: rtl/cross_channel_response_norm.sv
// Local response normalisation across channels, window of five channels.
// Input channel: i_in_valid / o_in_stall with i_in_value, one channel value of the
// current pixel per item, in channel order. Output channel: o_out_valid / i_out_stall
// with o_out_value, o_out_channel and o_run_last; an item moves on an edge with
// valid high and stall low. The result for channel c follows the input of channel
// c+2; the last channel of a pixel also flushes the two pending results, and
// o_run_last marks the final result caused by an input item.
// Each result is worked out in the shared normalisation unit over a window of w
// channels (w = 3 to 5): two bit-serial square roots of (3*DATA_WIDTH+14)/2 steps
// each and a restoring division of DATA_WIDTH+16 steps dominate the work. An item
// causing no result leaves the input free for the next item; one item can cause up
// to three. o_in_stall is high while the item's results are being worked out.
// A finished result waits in the output register while the receiver stalls; the
// next input item is accepted meanwhile, and further work waits for that register.
// Synchronous reset clears the channel position, the value window and the output
// valid, and restores the configuration registers to their defaults.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
// Depends on ccrn_pkg and ccrn_norm_unit.
module cross_channel_response_norm
    import ccrn_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_in_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_out_value,
    output logic [CCRN_CH_W-1:0]         o_out_channel,
    output logic                         o_run_last,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [CCRN_CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } t_state;

    t_state                              r_state;
    logic [CCRN_ALPHA_W-1:0]             r_alpha;
    logic [CCRN_BIAS_W-1:0]              r_bias;
    logic [CCRN_CH_W-1:0]                r_count;
    logic [CCRN_WIN-1:0][DATA_WIDTH-1:0] r_vals;
    logic [CCRN_CH_W-1:0]                r_pos;
    logic [CCRN_CH_W-1:0]                r_p;
    logic [2:0]                          r_hi;
    logic [1:0]                          r_center;
    logic [1:0]                          r_end;
    logic                                r_out_valid;
    logic [DATA_WIDTH-1:0]               r_out_value;
    logic [CCRN_CH_W-1:0]                r_out_channel;
    logic                                r_out_last;

    logic [CCRN_CH_W-1:0]  cnt_eff;
    logic                  in_accept;
    logic                  is_last;
    logic                  has_mid;
    logic [2:0]            hi;
    logic [2:0]            c_top;
    t_job                  job;
    logic                  unit_done;
    logic [DATA_WIDTH-1:0] unit_value;
    logic                  unit_ack;

    always_comb begin
        cnt_eff = r_count;
        if (r_count < CCRN_MIN_CHANNELS) begin
            cnt_eff = CCRN_MIN_CHANNELS;
        end else if (r_count > CCRN_MAX_CHANNELS) begin
            cnt_eff = CCRN_MAX_CHANNELS;
        end
    end

    assign in_accept    = i_in_valid && (r_state == ST_IDLE);
    assign is_last      = (r_pos >= (cnt_eff - CCRN_CH_W'(1)));
    assign has_mid      = (r_pos >= CCRN_CH_W'(2));
    assign hi           = (r_pos >= CCRN_CH_W'(4)) ? 3'd4 : r_pos[2:0];
    assign c_top        = {1'b0, r_center} + 3'd2;
    assign job.center   = r_center;
    assign job.last_idx = (c_top > r_hi) ? r_hi : c_top;
    assign unit_ack     = unit_done && (r_state == ST_WAIT) &&
                          (!r_out_valid || !i_out_stall);

    ccrn_norm_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ISSUE),
        .i_job   (job),
        .i_vals  (r_vals),
        .i_alpha (r_alpha),
        .i_bias  (r_bias),
        .i_ack   (unit_ack),
        .o_done  (unit_done),
        .o_value (unit_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alpha     <= CCRN_ALPHA_RST;
            r_bias      <= CCRN_BIAS_RST;
            r_count     <= CCRN_COUNT_RST;
            r_vals      <= '0;
            r_pos       <= '0;
            r_p         <= '0;
            r_hi        <= '0;
            r_center    <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CCRN_CFG_ALPHA: r_alpha <= i_cfg_data[CCRN_ALPHA_W-1:0];
                    CCRN_CFG_BIAS:  r_bias  <= i_cfg_data[CCRN_BIAS_W-1:0];
                    CCRN_CFG_COUNT: r_count <= i_cfg_data[CCRN_CH_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (unit_ack) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_vals <= {r_vals[CCRN_WIN-2:0], i_in_value};
                        r_p    <= r_pos;
                        r_hi   <= hi;
                        r_pos  <= is_last ? '0 : r_pos + CCRN_CH_W'(1);
                        if (has_mid || is_last) begin
                            r_center <= has_mid ? 2'd2 : 2'd1;
                            r_end    <= is_last ? 2'd0 : 2'd2;
                            r_state  <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (unit_ack) begin
                        r_out_value   <= unit_value;
                        r_out_channel <= r_p - CCRN_CH_W'(r_center);
                        r_out_last    <= (r_center == r_end);
                        if (r_center == r_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_center <= r_center - 2'd1;
                            r_state  <= ST_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_channel = r_out_channel;
    assign o_run_last    = r_out_last;

endmodule
